### design/imhq_pkg.sv
package imhq_pkg;

  localparam int HANDLES  = 1024;
  localparam int KEY_BITS = 32;
  localparam int HW       = $clog2(HANDLES + 1);
  localparam int AW       = $clog2(HANDLES);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_Q1,
    S_Q2,
    S_DEL_CHK,
    S_DEL_K,
    S_UP_P,
    S_UP_K,
    S_UP_C,
    S_DN_L,
    S_DN_LK,
    S_DN_R,
    S_DN_RK,
    S_DN_C,
    S_PLACE,
    S_FIN
  } state_t;

  // handles and positions count from 1, the stores from 0
  function automatic logic [AW-1:0] to_addr(input logic [HW-1:0] x);
    logic [HW-1:0] d;
    d = x - HW'(1);
    return d[AW-1:0];
  endfunction

endpackage

### design/indexed_min_heap_queue_core.sv
// channel  | valid     | stall     | payload
// request  | in_valid  | in_stall  | mode, key_value, handle
// result   | out_valid | out_stall | min_key, new_handle, status
//
// one request at a time; a query reads the root, a request rejected up front
// or a delete of an absent handle ends after its checks, an insert climbs the
// heap level by level, a delete of the last entry needs no reordering, any other
// delete moves the last entry into the gap and climbs or walks down (ten levels at
// most); the key, heap and position stores each have one read and one write port
// after reset all 1024 entries of the position store are cleared, with in_stall high
// a waiting result does not block the next request; a finished one waits
module indexed_min_heap_queue_core import imhq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic signed [31:0]         key_value,
  input  logic [10:0]                handle,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         min_key,
  output logic [10:0]                new_handle,
  output logic [1:0]                 status
);

  logic signed [KEY_BITS-1:0] key_mem [HANDLES];
  logic [HW-1:0]              hs_mem  [HANDLES];
  logic [HW-1:0]              sl_mem  [HANDLES];

  logic                       key_we, hs_we, sl_we;
  logic [AW-1:0]              key_wa, hs_wa, sl_wa, key_ra, hs_ra, sl_ra;
  logic signed [KEY_BITS-1:0] key_wd, key_rd;
  logic [HW-1:0]              hs_wd, sl_wd, hs_rd, sl_rd;

  state_t                     state, state_next;
  logic [AW-1:0]              clr_idx;
  logic [HW-1:0]              heap_count, next_handle;
  logic [HW-1:0]              pos, cpos, mh, ph, lh, rh, ch, dh;
  logic signed [KEY_BITS-1:0] mk, ck;
  logic                       is_del, moved;
  logic signed [31:0]         res_min;
  logic [HW-1:0]              res_h;
  logic [1:0]                 res_st;

  logic          accept, handle_ok, has_right, has_left, out_free;
  logic [HW:0]   pos2;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign handle_ok = (handle != '0) && (HW'(handle) <= HW'(HANDLES));
  assign pos2      = {pos, 1'b0};
  assign has_left  = pos2 <= {1'b0, heap_count};
  assign has_right = {pos, 1'b1} <= {1'b0, heap_count};
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_rd <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
    hs_rd <= hs_mem[hs_ra];
  end

  always_ff @(posedge clk) begin
    if (sl_we) sl_mem[sl_wa] <= sl_wd;
    sl_rd <= sl_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    key_we = 1'b0; key_wa = '0; key_wd = key_value[KEY_BITS-1:0]; key_ra = '0;
    hs_we  = 1'b0; hs_wa  = '0; hs_wd  = mh; hs_ra = '0;
    sl_we  = 1'b0; sl_wa  = '0; sl_wd  = pos; sl_ra = '0;
    case (state)
      S_CLR: begin
        sl_we = 1'b1;
        sl_wa = clr_idx;
        sl_wd = '0;
        if (clr_idx == AW'(HANDLES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_FIN;
          case (mode)
            MODE_INSERT: begin
              if (next_handle < HW'(HANDLES)) begin
                key_we = 1'b1;
                key_wa = next_handle[AW-1:0];
                state_next = S_UP_P;
              end
            end
            MODE_DELETE: begin
              sl_ra = to_addr(handle);
              hs_ra = to_addr(heap_count);
              if (handle_ok) state_next = S_DEL_CHK;
            end
            MODE_QUERY: begin
              hs_ra = '0;
              if (heap_count != '0) state_next = S_Q1;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_Q1: begin
        key_ra = to_addr(hs_rd);
        state_next = S_Q2;
      end
      S_Q2: state_next = S_FIN;
      S_DEL_CHK: begin
        if (sl_rd == '0) begin
          state_next = S_FIN;
        end else begin
          sl_we = 1'b1;
          sl_wa = to_addr(dh);
          sl_wd = '0;
          key_ra = to_addr(hs_rd);
          state_next = (sl_rd == heap_count) ? S_FIN : S_DEL_K;
        end
      end
      S_DEL_K: state_next = S_UP_P;
      S_UP_P: begin
        hs_ra = to_addr(pos >> 1);
        if (pos <= HW'(1)) state_next = (is_del && !moved) ? S_DN_L : S_PLACE;
        else               state_next = S_UP_K;
      end
      S_UP_K: begin
        key_ra = to_addr(hs_rd);
        state_next = S_UP_C;
      end
      S_UP_C: begin
        if (mk < key_rd) begin
          hs_we = 1'b1; hs_wa = to_addr(pos); hs_wd = ph;
          sl_we = 1'b1; sl_wa = to_addr(ph); sl_wd = pos;
          state_next = S_UP_P;
        end else begin
          state_next = (is_del && !moved) ? S_DN_L : S_PLACE;
        end
      end
      S_DN_L: begin
        hs_ra = to_addr(pos2[HW-1:0]);
        state_next = has_left ? S_DN_LK : S_PLACE;
      end
      S_DN_LK: begin
        key_ra = to_addr(hs_rd);
        hs_ra  = pos2[AW-1:0];
        state_next = S_DN_R;
      end
      S_DN_R: begin
        key_ra = to_addr(hs_rd);
        state_next = has_right ? S_DN_RK : S_DN_C;
      end
      S_DN_RK: state_next = S_DN_C;
      S_DN_C: begin
        if (ck < mk) begin
          hs_we = 1'b1; hs_wa = to_addr(pos); hs_wd = ch;
          sl_we = 1'b1; sl_wa = to_addr(ch); sl_wd = pos;
          state_next = S_DN_L;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        hs_we = 1'b1; hs_wa = to_addr(pos); hs_wd = mh;
        sl_we = 1'b1; sl_wa = to_addr(mh); sl_wd = pos;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx     <= '0;
      heap_count  <= '0;
      next_handle <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLR: clr_idx <= clr_idx + AW'(1);
        S_IDLE: begin
          if (accept) begin
            res_min <= '0;
            res_h   <= '0;
            res_st  <= ST_OK;
            is_del  <= (mode == MODE_DELETE);
            moved   <= 1'b0;
            dh      <= handle;
            case (mode)
              MODE_INSERT: begin
                if (next_handle < HW'(HANDLES)) begin
                  next_handle <= next_handle + HW'(1);
                  heap_count  <= heap_count + HW'(1);
                  pos         <= heap_count + HW'(1);
                  mh          <= next_handle + HW'(1);
                  mk          <= key_value[KEY_BITS-1:0];
                  res_h       <= next_handle + HW'(1);
                end else begin
                  res_st <= ST_FULL;
                end
              end
              MODE_DELETE: if (!handle_ok) res_st <= ST_ABSENT;
              MODE_QUERY:  if (heap_count == '0) res_st <= ST_ABSENT;
              default: res_st <= ST_OK;
            endcase
          end
        end
        S_Q2: res_min <= 32'(key_rd);
        S_DEL_CHK: begin
          if (sl_rd == '0) begin
            res_st <= ST_ABSENT;
          end else begin
            heap_count <= heap_count - HW'(1);
            mh         <= hs_rd;
            pos        <= sl_rd;
          end
        end
        S_DEL_K: mk <= key_rd;
        S_UP_K:  ph <= hs_rd;
        S_UP_C: begin
          if (mk < key_rd) begin
            pos   <= pos >> 1;
            moved <= 1'b1;
          end
        end
        S_DN_LK: lh <= hs_rd;
        S_DN_R: begin
          ch   <= lh;
          ck   <= key_rd;
          cpos <= pos2[HW-1:0];
          rh   <= hs_rd;
        end
        S_DN_RK: begin
          if (key_rd < ck) begin
            ch   <= rh;
            ck   <= key_rd;
            cpos <= HW'({pos, 1'b1});
          end
        end
        S_DN_C: if (ck < mk) pos <= cpos;
        S_FIN: begin
          if (out_free) begin
            min_key    <= res_min;
            new_handle <= res_h;
            status     <= res_st;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### tb/tb_indexed_min_heap_queue_core.sv
`timescale 1ns / 1ps

module tb_indexed_min_heap_queue_core;
  import imhq_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  int     fails = 0;
  longint cycles = 0;

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at cycle %0d: %s", cycles, msg);
    fails++;
  endtask

  class heap_scoreboard;
    logic signed [31:0] key_of [1:HANDLES];
    int unsigned        heap_at [1:HANDLES];
    int unsigned        pos_of [0:HANDLES];
    int unsigned        count;
    int unsigned        issued;
    logic signed [31:0] exp_key [$];
    logic [10:0]        exp_handle [$];
    logic [1:0]         exp_status [$];
    int                 errors;
    int                 checked;

    function new();
      for (int i = 0; i <= HANDLES; i++) pos_of[i] = 0;
      count = 0;
      issued = 0;
      errors = 0;
      checked = 0;
    endfunction

    function bit less(int unsigned a, int unsigned b);
      return key_of[a] < key_of[b];
    endfunction

    function void swap(int unsigned a, int unsigned b);
      int unsigned t;
      t = heap_at[a];
      heap_at[a] = heap_at[b];
      heap_at[b] = t;
      pos_of[heap_at[a]] = a;
      pos_of[heap_at[b]] = b;
    endfunction

    function int unsigned climb(int unsigned p);
      while (p > 1 && less(heap_at[p], heap_at[p / 2])) begin
        swap(p, p / 2);
        p = p / 2;
      end
      return p;
    endfunction

    function void sink(int unsigned p);
      int unsigned c;
      while (2 * p <= count) begin
        c = 2 * p;
        if (c + 1 <= count && less(heap_at[c + 1], heap_at[c])) c++;
        if (!less(heap_at[c], heap_at[p])) break;
        swap(c, p);
        p = c;
      end
    endfunction

    function void note_request(logic [1:0] m, logic signed [31:0] k, logic [10:0] h);
      logic signed [31:0] mk;
      logic [10:0]        nh;
      logic [1:0]         st;
      int unsigned        p;
      mk = 0;
      nh = 0;
      st = ST_OK;
      if (m == MODE_INSERT) begin
        if (issued >= HANDLES) st = ST_FULL;
        else begin
          issued++;
          key_of[issued] = k;
          count++;
          heap_at[count] = issued;
          pos_of[issued] = count;
          p = climb(count);
          nh = 11'(issued);
        end
      end else if (m == MODE_DELETE) begin
        if (h == 0 || h > HANDLES || pos_of[h] == 0) st = ST_ABSENT;
        else begin
          p = pos_of[h];
          if (p != count) begin
            heap_at[p] = heap_at[count];
            pos_of[heap_at[p]] = p;
          end
          pos_of[h] = 0;
          count--;
          if (p <= count) begin
            p = climb(p);
            sink(p);
          end
        end
      end else if (m == MODE_QUERY) begin
        if (count == 0) st = ST_ABSENT;
        else mk = key_of[heap_at[1]];
      end
      exp_key.push_back(mk);
      exp_handle.push_back(nh);
      exp_status.push_back(st);
    endfunction

    task check_result(logic signed [31:0] mk, logic [10:0] nh, logic [1:0] st);
      logic signed [31:0] ek;
      logic [10:0]        eh;
      logic [1:0]         es;
      checked++;
      if (exp_key.size() == 0) begin
        report_mismatch($sformatf("unexpected result key=%0d handle=%0d status=%0d",
                                  mk, nh, st));
        return;
      end
      ek = exp_key.pop_front();
      eh = exp_handle.pop_front();
      es = exp_status.pop_front();
      if (mk !== ek) report_mismatch($sformatf("min_key %0d, want %0d", mk, ek));
      if (nh !== eh) report_mismatch($sformatf("new_handle %0d, want %0d", nh, eh));
      if (st !== es) report_mismatch($sformatf("status %0d, want %0d", st, es));
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         mode = MODE_QUERY;
  logic signed [31:0] key_value = 0;
  logic [10:0]        handle = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] min_key;
  logic [10:0]        new_handle;
  logic [1:0]         status;

  heap_scoreboard board;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   sent = 0;
  int   ops_seen [4];

  indexed_min_heap_queue_core uut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) board.check_result(min_key, new_handle, status);

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_idle);

  // returns at the accepting edge; the next request or idle starts at the falling edge
  task automatic send(logic [1:0] m, logic signed [31:0] k, logic [10:0] h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    mode <= m;
    key_value <= k;
    handle <= h;
    do @(posedge clk); while (in_stall);
    board.note_request(m, k, h);
    ops_seen[m]++;
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.exp_key.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // mixed requests: deletes mostly name issued handles, narrow keys for ties, some unused modes
  task automatic random_request();
    int unsigned r;
    logic signed [31:0] k;
    logic [10:0] h;
    r = $urandom_range(99);
    k = ($urandom_range(3) == 0) ? $signed($urandom) : $signed($urandom_range(40)) - 20;
    if (r < 45) send(MODE_INSERT, k, 0);
    else if (r < 75) begin
      if (board.issued > 0 && $urandom_range(9) != 0)
        h = 11'($urandom_range(board.issued, 1));
      else h = 11'($urandom);
      send(MODE_DELETE, k, h);
    end else if (r < 97) send(MODE_QUERY, k, 11'($urandom));
    else send(MODE_UNUSED, k, 11'($urandom));
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed corners
    send(MODE_QUERY, 0, 0);
    send(MODE_DELETE, 0, 1);
    send(MODE_DELETE, 0, 0);
    send(MODE_INSERT, 32'sh7fffffff, 0);
    send(MODE_INSERT, 32'sh80000000, 0);
    send(MODE_INSERT, 5, 0);
    send(MODE_INSERT, 5, 0);
    send(MODE_INSERT, -1, 0);
    send(MODE_QUERY, 0, 11'h7ff);
    send(MODE_UNUSED, -1, 11'h7ff);
    send(MODE_DELETE, 0, 2);
    send(MODE_QUERY, 0, 0);
    send(MODE_DELETE, 0, 2);
    send(MODE_DELETE, 0, 11'd1025);
    send(MODE_DELETE, 0, 11'h7ff);
    send(MODE_DELETE, 0, 9);
    send(MODE_DELETE, 0, 5);
    send(MODE_DELETE, 0, 3);
    send(MODE_QUERY, 0, 0);
    send(MODE_DELETE, 0, 1);
    send(MODE_DELETE, 0, 4);
    send(MODE_QUERY, 0, 0);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 18 : (phase == 1) ? 64 : 0;
      recv_idle = (phase == 0) ? 64 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < 276; i++) random_request();
      drain();
    end
    $display("tb: %0d requests (%0d insert, %0d delete, %0d query, %0d unknown), %0d results",
             sent, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], board.checked);
    $display("tb: %0d handles issued under three stall mixes, %0d left in heap",
             board.issued, board.count);
    if (fails == 0 && board.errors == 0 && board.exp_key.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
